// ===== rtl/rnpi_pkg.sv =====
`timescale 1ns / 1ps

package rnpi_pkg;

    // pixel component and unit (q1.16) formats
    localparam int PIX_W   = 8;
    localparam int UNIT_W  = 17;
    localparam int SQ_W    = 2 * UNIT_W;
    localparam int DIST_W  = SQ_W + 2;
    localparam int ROW_W   = 6;
    localparam int IDX_W   = 4;
    localparam int CHANS   = 3;

    // long division: 16 fraction bits, four per stage
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = 16 / DIV_BITS_PER_STAGE;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [UNIT_W-1:0] unit_t;
    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [ROW_W-1:0]  row_t;

    localparam unit_t UNIT_ONE = unit_t'(65536);

    // one candidate in the comparison tree
    typedef struct packed {
        logic  pad;      // filler leaf, never wins against a real entry
        dist_t dist_sum;
        logic  not_last; // clear only on the preferred (last) entry
        row_t  idx;
    } cand_t;

    // partial result of a group of division steps
    typedef struct packed {
        pix_t                          rem;
        logic [DIV_BITS_PER_STAGE-1:0] q;
    } div_part_t;

    // palette colors scaled by their own largest component
    localparam unit_t PAL_TAB [16][CHANS] = '{
        '{unit_t'(0),     unit_t'(0),     unit_t'(0)},
        '{UNIT_ONE,       unit_t'(0),     unit_t'(0)},
        '{unit_t'(0),     UNIT_ONE,       unit_t'(0)},
        '{unit_t'(40910), UNIT_ONE,       unit_t'(37732)},
        '{unit_t'(0),     unit_t'(0),     UNIT_ONE},
        '{UNIT_ONE,       unit_t'(0),     UNIT_ONE},
        '{unit_t'(0),     UNIT_ONE,       UNIT_ONE},
        '{UNIT_ONE,       UNIT_ONE,       UNIT_ONE},
        '{UNIT_ONE,       UNIT_ONE,       UNIT_ONE},
        '{UNIT_ONE,       unit_t'(0),     unit_t'(0)},
        '{unit_t'(0),     UNIT_ONE,       unit_t'(0)},
        '{UNIT_ONE,       unit_t'(32896), unit_t'(0)},
        '{unit_t'(0),     unit_t'(0),     UNIT_ONE},
        '{UNIT_ONE,       unit_t'(0),     UNIT_ONE},
        '{unit_t'(0),     UNIT_ONE,       UNIT_ONE},
        '{UNIT_ONE,       UNIT_ONE,       UNIT_ONE}
    };

    // rows past the fixed colors hold scaled black
    function automatic unit_t palette_unit(input row_t row, input logic [1:0] chan);
        unit_t v;
        v = '0;
        if (row[ROW_W-1:4] == '0 && chan != 2'd3) begin
            v = PAL_TAB[row[3:0]][chan];
        end
        return v;
    endfunction

    // restoring division steps, shifting in zero dividend bits; rem < m on entry
    // a zero divisor yields zero quotient bits (black pixel)
    function automatic div_part_t div_steps(input pix_t rem_in, input pix_t m);
        logic [PIX_W:0] t;
        div_part_t      res;
        res.rem = rem_in;
        res.q   = '0;
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
            t = {res.rem, 1'b0};
            if (m != '0 && t >= {1'b0, m}) begin
                t = t - {1'b0, m};
                res.q = {res.q[DIV_BITS_PER_STAGE-2:0], 1'b1};
            end else begin
                res.q = {res.q[DIV_BITS_PER_STAGE-2:0], 1'b0};
            end
            res.rem = t[PIX_W-1:0];
        end
        return res;
    endfunction

    // left candidate has the lower index and wins ties
    function automatic cand_t pick(input cand_t a, input cand_t b);
        if ({a.pad, a.dist_sum, a.not_last} <= {b.pad, b.dist_sum, b.not_last}) begin
            return a;
        end
        return b;
    endfunction

endpackage

// ===== rtl/rgb_nearest_palette_index_core.sv =====
`timescale 1ns / 1ps

// channel   ports                                              direction
// request   s_valid s_ready s_red_level s_green_level s_blue_level  in
// result    m_valid m_ready m_palette_index                    out
//
// one pixel per clock sustained while m_ready stays high; the pipeline is the
// input register, the four stages of the long divider that scale each
// component (four quotient bits per stage), the squared-difference and leaf
// registers, and the registered comparison tree, one level per stage
// synchronous active-low reset clears only the valid bits
// each stage holds while its successor is full and stalled; an empty stage
// keeps taking data, so bubbles close up and nothing is lost or repeated

module rgb_nearest_palette_index_core #(
    parameter int PALETTE_ENTRIES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rnpi_pkg::pix_t        s_red_level,
    input  rnpi_pkg::pix_t        s_green_level,
    input  rnpi_pkg::pix_t        s_blue_level,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [rnpi_pkg::IDX_W-1:0] m_palette_index
);

    localparam int LEVELS  = $clog2(PALETTE_ENTRIES);
    localparam int LEAVES  = 1 << LEVELS;
    localparam int NODES   = 2 * LEAVES - 1;
    localparam int DIVS    = rnpi_pkg::DIV_STAGES;
    localparam int ST_IN   = 0;
    localparam int ST_DIV  = 1;
    localparam int ST_SQ   = ST_DIV + DIVS;
    localparam int ST_LEAF = ST_SQ + 1;
    localparam int NSTG    = ST_LEAF + LEVELS + 1;
    localparam int DBITS   = rnpi_pkg::DIV_BITS_PER_STAGE;
    localparam int UW      = rnpi_pkg::UNIT_W;

    // stage valids and per-stage load enables
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    // input stage: raw components and their maximum
    rnpi_pkg::pix_t c_in_reg [rnpi_pkg::CHANS];
    rnpi_pkg::pix_t m_in_reg;
    rnpi_pkg::pix_t max_in;

    // divider stages
    rnpi_pkg::pix_t dv_rem_reg  [DIVS][rnpi_pkg::CHANS];
    rnpi_pkg::unit_t dv_q_reg   [DIVS][rnpi_pkg::CHANS];
    rnpi_pkg::pix_t dv_m_reg    [DIVS];
    rnpi_pkg::pix_t dv_rem_next [DIVS][rnpi_pkg::CHANS];
    rnpi_pkg::unit_t dv_q_next  [DIVS][rnpi_pkg::CHANS];

    // squared differences, one per entry and channel
    rnpi_pkg::sq_t sq_reg  [LEAVES][rnpi_pkg::CHANS];
    rnpi_pkg::sq_t sq_next [LEAVES][rnpi_pkg::CHANS];

    // comparison tree in heap order: root at 0, leaves at LEAVES-1 upward
    rnpi_pkg::cand_t cand_reg  [NODES];
    rnpi_pkg::cand_t leaf_next [LEAVES];

    // ready ripples back: a stage loads when empty or when its successor loads
    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_ready         = en[ST_IN];
    assign m_valid         = vld_reg[NSTG-1];
    assign m_palette_index = cand_reg[0].idx[rnpi_pkg::IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= (k == 0) ? s_valid : vld_reg[k-1];
                end
            end
        end
    end

    // largest component
    always_comb begin
        max_in = s_red_level;
        if (s_green_level > max_in) begin
            max_in = s_green_level;
        end
        if (s_blue_level > max_in) begin
            max_in = s_blue_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_IN]) begin
            c_in_reg[0] <= s_red_level;
            c_in_reg[1] <= s_green_level;
            c_in_reg[2] <= s_blue_level;
            m_in_reg    <= max_in;
        end
    end

    // (c << 16) / m with c <= m: the integer bit is set only when c == m
    // (and m is nonzero); otherwise the remainder starts at c and sixteen
    // fraction bits follow
    always_comb begin
        rnpi_pkg::div_part_t part;
        rnpi_pkg::pix_t      rem_src;
        rnpi_pkg::unit_t     q_src;
        rnpi_pkg::pix_t      m_src;
        for (int s = 0; s < DIVS; s++) begin
            for (int k = 0; k < rnpi_pkg::CHANS; k++) begin
                if (s == 0) begin
                    m_src   = m_in_reg;
                    rem_src = (c_in_reg[k] == m_in_reg) ? '0 : c_in_reg[k];
                    q_src   = {{(UW-1){1'b0}},
                               (c_in_reg[k] == m_in_reg) && (m_in_reg != '0)};
                end else begin
                    m_src   = dv_m_reg[s-1];
                    rem_src = dv_rem_reg[s-1][k];
                    q_src   = dv_q_reg[s-1][k];
                end
                part              = rnpi_pkg::div_steps(rem_src, m_src);
                dv_rem_next[s][k] = part.rem;
                dv_q_next[s][k]   = {q_src[UW-DBITS-1:0], part.q};
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < DIVS; s++) begin
            if (en[ST_DIV+s]) begin
                dv_m_reg[s] <= (s == 0) ? m_in_reg : dv_m_reg[s-1];
                for (int k = 0; k < rnpi_pkg::CHANS; k++) begin
                    dv_rem_reg[s][k] <= dv_rem_next[s][k];
                    dv_q_reg[s][k]   <= dv_q_next[s][k];
                end
            end
        end
    end

    // squared difference to every palette entry; filler leaves compute too
    always_comb begin
        rnpi_pkg::unit_t p;
        rnpi_pkg::unit_t px;
        rnpi_pkg::unit_t d;
        for (int j = 0; j < LEAVES; j++) begin
            for (int k = 0; k < rnpi_pkg::CHANS; k++) begin
                p  = rnpi_pkg::palette_unit(rnpi_pkg::row_t'(j), 2'(k));
                px = dv_q_reg[DIVS-1][k];
                d  = (p >= px) ? (p - px) : (px - p);
                sq_next[j][k] = rnpi_pkg::sq_t'(d) * rnpi_pkg::sq_t'(d);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SQ]) begin
            sq_reg <= sq_next;
        end
    end

    // leaf keys: the last real entry is preferred on equal distance
    always_comb begin
        for (int j = 0; j < LEAVES; j++) begin
            leaf_next[j].pad      = (j >= PALETTE_ENTRIES);
            leaf_next[j].dist_sum = rnpi_pkg::dist_t'(sq_reg[j][0])
                                  + rnpi_pkg::dist_t'(sq_reg[j][1])
                                  + rnpi_pkg::dist_t'(sq_reg[j][2]);
            leaf_next[j].not_last = (j != PALETTE_ENTRIES - 1);
            leaf_next[j].idx      = rnpi_pkg::row_t'(j);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_LEAF]) begin
            for (int j = 0; j < LEAVES; j++) begin
                cand_reg[LEAVES-1+j] <= leaf_next[j];
            end
        end
        // one tree level per stage, root is the last stage
        for (int d = 0; d < LEVELS; d++) begin
            if (en[ST_LEAF+LEVELS-d]) begin
                for (int i = (1 << d) - 1; i < (2 << d) - 1; i++) begin
                    cand_reg[i] <= rnpi_pkg::pick(cand_reg[2*i+1], cand_reg[2*i+2]);
                end
            end
        end
    end

endmodule

// ===== tb/sv/rgb_nearest_palette_index_core_tb.sv =====
`timescale 1ns / 1ps

module rgb_nearest_palette_index_core_tb;

    localparam int PALETTE_ENTRIES = 16;
    localparam int LAST_ENTRY      = PALETTE_ENTRIES - 1;
    localparam int RANDOM_PIXELS   = 400;
    localparam int DRAIN_CYCLES    = 24;   // a bit over twice the pipeline depth
    localparam int LONG_HOLD       = 80;
    localparam int MAX_REPORTS     = 10;
    localparam int unsigned UNIT   = 65536;

    // palette entries already divided by their own largest component, q1.16
    localparam int unsigned SCALED_COLOR [16][3] = '{
        '{0, 0, 0},
        '{UNIT, 0, 0},
        '{0, UNIT, 0},
        '{40910, UNIT, 37732},
        '{0, 0, UNIT},
        '{UNIT, 0, UNIT},
        '{0, UNIT, UNIT},
        '{UNIT, UNIT, UNIT},
        '{UNIT, UNIT, UNIT},
        '{UNIT, 0, 0},
        '{0, UNIT, 0},
        '{UNIT, 32896, 0},
        '{0, 0, UNIT},
        '{UNIT, 0, UNIT},
        '{0, UNIT, UNIT},
        '{UNIT, UNIT, UNIT}
    };

    // directed pixels, {red, green, blue}
    localparam logic [23:0] DIRECTED_PIXELS [24] = '{
        24'h000000,     // black scales to zeros
        24'hFFFFFF,     // white, ties with both grays
        24'h010101,     // smallest gray
        24'h8B0000, 24'h006400, 24'h67A55F, 24'h00008B,
        24'hD3D3D3, 24'hA9A9A9, 24'hFF8000,
        24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'hFF00FF, 24'h00FFFF,
        24'h010000, 24'h000001,
        24'hFF4000,     // between red and orange
        24'hFFC000,     // between orange and yellow
        24'h80807F, 24'h7F8080,
        24'h808080,
        24'hFE01FF
    };

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    rnpi_pkg::pix_t s_red_level;
    rnpi_pkg::pix_t s_green_level;
    rnpi_pkg::pix_t s_blue_level;
    logic m_valid;
    logic m_ready;
    logic [rnpi_pkg::IDX_W-1:0] m_palette_index;

    // one request still owed a result
    typedef struct {
        logic [23:0]                pixel;
        logic [rnpi_pkg::IDX_W-1:0] index;
    } owed_index_t;

    class palette_index_board;
        owed_index_t owed[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // nearest palette entry after scaling by the largest component
        function logic [rnpi_pkg::IDX_W-1:0] nearest_index(rnpi_pkg::pix_t r,
                                                           rnpi_pkg::pix_t g,
                                                           rnpi_pkg::pix_t b);
            int unsigned       peak;
            int unsigned       unit_val [3];
            int unsigned       comp [3];
            longint unsigned   sq_dist;
            longint unsigned   best_dist;
            longint unsigned   diff;
            int                best;
            comp[0] = r;
            comp[1] = g;
            comp[2] = b;
            peak = comp[0];
            if (comp[1] > peak) peak = comp[1];
            if (comp[2] > peak) peak = comp[2];
            for (int k = 0; k < 3; k++) begin
                unit_val[k] = (peak == 0) ? 0 : (comp[k] << 16) / peak;
            end
            best = -1;
            best_dist = 0;
            // the last entry is the starting best, so it wins every tie
            for (int i = LAST_ENTRY; i < PALETTE_ENTRIES + LAST_ENTRY; i++) begin
                sq_dist = 0;
                for (int k = 0; k < 3; k++) begin
                    diff = (SCALED_COLOR[i % PALETTE_ENTRIES][k] >= unit_val[k])
                         ? SCALED_COLOR[i % PALETTE_ENTRIES][k] - unit_val[k]
                         : unit_val[k] - SCALED_COLOR[i % PALETTE_ENTRIES][k];
                    sq_dist += diff * diff;
                end
                // other ties go to the lowest index, strict compare keeps it
                if (best < 0 || sq_dist < best_dist) begin
                    best = i % PALETTE_ENTRIES;
                    best_dist = sq_dist;
                end
            end
            return best[rnpi_pkg::IDX_W-1:0];
        endfunction

        function void note_pixel(rnpi_pkg::pix_t r, rnpi_pkg::pix_t g, rnpi_pkg::pix_t b);
            owed_index_t e;
            e.pixel = {r, g, b};
            e.index = nearest_index(r, g, b);
            owed.push_back(e);
        endfunction

        function void check_index(logic [rnpi_pkg::IDX_W-1:0] got);
            owed_index_t e;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result %0d with no request pending", got);
                return;
            end
            e = owed.pop_front();
            if (got !== e.index) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("pixel %h: expected index %0d, got %0d", e.pixel, e.index, got);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    palette_index_board board;
    bit no_idle;        // both sides skip their gaps while set
    int hold_request;   // receiver picks this up and holds off that many cycles

    rgb_nearest_palette_index_core #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red_level    (s_red_level),
        .s_green_level  (s_green_level),
        .s_blue_level   (s_blue_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_palette_index(m_palette_index)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // offer one request, optionally after a gap; returns at the falling edge
    // after acceptance with valid still high, so back-to-back requests never
    // lower and raise valid in one step
    task automatic send_pixel(input rnpi_pkg::pix_t r, input rnpi_pkg::pix_t g,
                              input rnpi_pkg::pix_t b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_red_level   <= r;
        s_green_level <= g;
        s_blue_level  <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
        board.note_pixel(r, g, b);
        @(negedge aclk);
    endtask

    // random pixel with a shape picked to stress scaling and ties
    task automatic send_random_pixel();
        int             shape;
        rnpi_pkg::pix_t c [3];
        rnpi_pkg::pix_t base;
        int             k;
        shape = $urandom_range(0, 5);
        for (int j = 0; j < 3; j++) c[j] = rnpi_pkg::pix_t'($urandom_range(0, 255));
        k = $urandom_range(0, 2);
        case (shape)
            1: begin
                // one channel off, the other two mixed
                c[k] = '0;
            end
            2: begin
                // near gray, pulls toward the white tie
                base = rnpi_pkg::pix_t'($urandom_range(4, 251));
                for (int j = 0; j < 3; j++)
                    c[j] = base + rnpi_pkg::pix_t'($urandom_range(0, 6))
                         - rnpi_pkg::pix_t'(3);
            end
            3: begin
                // tiny values, coarse quotients
                for (int j = 0; j < 3; j++) c[j] = rnpi_pkg::pix_t'($urandom_range(0, 7));
            end
            4: begin
                // one channel saturated
                c[k] = 8'hFF;
            end
            default: begin
            end
        endcase
        send_pixel(c[0], c[1], c[2]);
    endtask

    // receiver: random stall per result, long hold when asked
    initial begin
        int stall;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            board.check_index(m_palette_index);
            @(negedge aclk);
        end
    end

    // main stimulus
    initial begin
        board         = new();
        no_idle       = 1'b0;
        hold_request  = 0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_red_level   = '0;
        s_green_level = '0;
        s_blue_level  = '0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed corners
        foreach (DIRECTED_PIXELS[i]) begin
            send_pixel(DIRECTED_PIXELS[i][23:16], DIRECTED_PIXELS[i][15:8],
                       DIRECTED_PIXELS[i][7:0]);
        end

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            // alternate idle and full-rate stretches
            if (n % 60 == 0) no_idle = ~no_idle;
            // long receiver hold while requests keep coming, pipe fills up
            if (n == 150) begin
                no_idle = 1'b1;
                hold_request = LONG_HOLD;
            end
            // sender waits for the pipe to empty out completely
            if (n == 260) begin
                s_valid <= 1'b0;
                while (board.pending() != 0) @(negedge aclk);
            end
            send_random_pixel();
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;

        // drain, then a few spare cycles to catch any extra result
        while (board.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rnpi_pkg.sv
rtl/rgb_nearest_palette_index_core.sv
tb/sv/rgb_nearest_palette_index_core_tb.sv
